@@ src/fsa_pkg.sv @@
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types, constants and codes for the Forth stack ALU core.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VAR_COUNT   = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int VA_W        = 4;

    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3,
        OP_DIV = 5'd4, OP_MOD = 5'd5, OP_NEG = 5'd6, OP_PRINT = 5'd7,
        OP_GT = 5'd8, OP_GE = 5'd9, OP_LT = 5'd10, OP_LE = 5'd11,
        OP_EQ = 5'd12, OP_NE = 5'd13, OP_DUP = 5'd14, OP_DROP = 5'd15,
        OP_SWAP = 5'd16, OP_ROT = 5'd17, OP_DEFINE = 5'd18, OP_FETCH = 5'd19,
        OP_STORE = 5'd20, OP_AND = 5'd21, OP_OR = 5'd22, OP_NOT = 5'd23
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZ = 3'd3,
        ST_NOTBOOL = 3'd4, ST_DUPVAR = 3'd5, ST_UNKVAR = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_DIV, S_WRITE, S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic        want_rem;
        logic [31:0] a;
        logic [31:0] b;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } div_rsp_t;

endpackage

@@ src/fsa_div.sv @@
// ----------------------------------------------------------------------------
// fsa_div
// Iterative signed truncating divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsa_div
    import fsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic        rem_reg, rem_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        shifted   = {r_reg[31:0], q_reg[31]};
        trial     = shifted - {1'b0, d_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            q_next    = req.a[31] ? (32'd0 - req.a) : req.a;
            d_next    = req.b[31] ? (32'd0 - req.b) : req.b;
            r_next    = 33'd0;
            rem_next  = req.want_rem;
            neg_next  = req.want_rem ? req.a[31] : (req.a[31] ^ req.b[31]);
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (rem_reg)
                    res_next = neg_reg ? (32'd0 - r_next[31:0]) : r_next[31:0];
                else
                    res_next = neg_reg ? (32'd0 - q_next) : q_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

@@ src/forth_stack_alu_core.sv @@
// ----------------------------------------------------------------------------
// forth_stack_alu_core
// Executes one Forth word per item on a data stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Steps: S_READ issues three stack reads, S_EXEC computes, S_WRITE writes up to
// three result words, S_OUT issues the result; multiply waits in S_DIV for the
// registered product, divide and modulo for the one-bit-per-cycle divider.
// A new item is taken only in S_IDLE; stack reads pass one at a time through
// the stack RAM read port and writes one at a time through its write port.
// Reset: stack pointer and variable defined bits clear; RAM contents are
// undefined until written.
module forth_stack_alu_core
    import fsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // mode[4:0], literal[36:5], var_index[40:37]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // status[2:0], emitted[3], emit_value[35:4],
                                  // stack_depth[42:36]
);

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] var_mem   [VAR_COUNT];

    state_t          state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [VAR_COUNT-1:0] def_reg, def_next;
    logic [1:0]      rcnt_reg, rcnt_next;
    logic [1:0]      wcnt_reg, wcnt_next;
    op_t             op_reg;
    logic [31:0]     lit_reg, var_rd_reg, rd_reg;
    logic [VA_W-1:0] vi_reg;
    logic [31:0]     a_reg, b_reg, c_reg, a_next, b_next, c_next;
    logic [31:0]     w0_reg, w1_reg, w2_reg, w0_next, w1_next, w2_next;
    logic [1:0]      nw_reg, nw_next;
    logic [SP_W-1:0] wbase_reg, wbase_next;
    status_t         st_reg, st_next;
    logic            em_reg, em_next;
    logic [31:0]     ev_reg, ev_next;
    logic            mv_reg, mv_next;
    logic [47:0]     out_reg, out_next;
    logic            mul_pend_reg, mul_pend_next;
    logic [31:0]     mul_reg;

    logic            rd_en;
    logic [SA_W-1:0] rd_addr;
    logic            wr_en;
    logic [SA_W-1:0] wr_addr;
    logic [31:0]     wr_data;
    logic            var_we;
    div_req_t        dreq;
    div_rsp_t        drsp;
    logic [SP_W-1:0] tmp_addr;
    logic            a_lt_b;
    logic            b_lt_a;
    logic            vi_bad;

    fsa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= stack_mem[rd_addr];
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        var_rd_reg <= var_mem[vi_reg];
        if (var_we)
            var_mem[vi_reg] <= b_reg;
        mul_reg <= a_reg * b_reg;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;
    assign a_lt_b   = $signed(a_reg) < $signed(b_reg);
    assign b_lt_a   = $signed(b_reg) < $signed(a_reg);
    assign vi_bad   = ({28'd0, vi_reg} >= 32'(VAR_COUNT));

    always_comb
    begin
        state_next = state_reg;
        sp_next = sp_reg;
        def_next = def_reg;
        rcnt_next = rcnt_reg;
        wcnt_next = wcnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        w0_next = w0_reg;
        w1_next = w1_reg;
        w2_next = w2_reg;
        nw_next = nw_reg;
        wbase_next = wbase_reg;
        st_next = st_reg;
        em_next = em_reg;
        ev_next = ev_reg;
        mv_next = mv_reg;
        out_next = out_reg;
        mul_pend_next = 1'b0;
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = w0_reg;
        var_we = 1'b0;
        dreq = '0;
        tmp_addr = '0;
        if (mv_reg && m_tready)
            mv_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = S_READ;
                    rcnt_next = 2'd0;
                end
            end
            S_READ:
            begin
                // Issue reads of top, second and third entries, capture lagged.
                if (rcnt_reg != 2'd0)
                begin
                    unique case (rcnt_reg)
                        2'd1:    b_next = rd_reg;
                        2'd2:    a_next = rd_reg;
                        default: c_next = rd_reg;
                    endcase
                end
                if (rcnt_reg == 2'd3)
                    state_next = S_EXEC;
                else
                begin
                    tmp_addr = sp_reg - SP_W'(rcnt_reg) - SP_W'(1);
                    rd_en = 1'b1;
                    rd_addr = tmp_addr[SA_W-1:0];
                    rcnt_next = rcnt_reg + 2'd1;
                end
            end
            S_EXEC:
            begin
                st_next = ST_OK;
                em_next = 1'b0;
                ev_next = 32'd0;
                nw_next = 2'd0;
                wbase_next = sp_reg;
                state_next = S_WRITE;
                wcnt_next = 2'd0;
                unique case (op_reg)
                    OP_PUSH, OP_DUP:
                    begin
                        if (op_reg == OP_DUP && sp_reg == '0)
                            st_next = ST_UNDER;
                        else if (sp_reg == SP_W'(STACK_DEPTH))
                            st_next = ST_OVER;
                        else
                        begin
                            w0_next = (op_reg == OP_PUSH) ? lit_reg : b_reg;
                            nw_next = 2'd1;
                            sp_next = sp_reg + SP_W'(1);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_GE,
                    OP_LT, OP_LE, OP_EQ, OP_NE, OP_SWAP, OP_AND, OP_OR:
                    begin
                        if (sp_reg < SP_W'(2))
                            st_next = ST_UNDER;
                        else
                        begin
                            wbase_next = sp_reg - SP_W'(2);
                            nw_next = 2'd1;
                            sp_next = sp_reg - SP_W'(1);
                            unique case (op_reg)
                                OP_ADD: w0_next = a_reg + b_reg;
                                OP_SUB: w0_next = a_reg - b_reg;
                                OP_MUL:
                                begin
                                    mul_pend_next = 1'b1;
                                    state_next = S_DIV;
                                end
                                OP_DIV, OP_MOD:
                                begin
                                    if (b_reg == 32'd0)
                                    begin
                                        st_next = ST_DIVZ;
                                        nw_next = 2'd0;
                                        sp_next = sp_reg;
                                    end
                                    else
                                    begin
                                        dreq.start = 1'b1;
                                        dreq.want_rem = (op_reg == OP_MOD);
                                        dreq.a = a_reg;
                                        dreq.b = b_reg;
                                        state_next = S_DIV;
                                    end
                                end
                                OP_GT: w0_next = {31'd0, b_lt_a};
                                OP_GE: w0_next = {31'd0, !a_lt_b};
                                OP_LT: w0_next = {31'd0, a_lt_b};
                                OP_LE: w0_next = {31'd0, !b_lt_a};
                                OP_EQ: w0_next = {31'd0, a_reg == b_reg};
                                OP_NE: w0_next = {31'd0, a_reg != b_reg};
                                OP_SWAP:
                                begin
                                    w0_next = b_reg;
                                    w1_next = a_reg;
                                    nw_next = 2'd2;
                                    sp_next = sp_reg;
                                end
                                default:
                                begin
                                    if (a_reg > 32'd1 || b_reg > 32'd1)
                                    begin
                                        st_next = ST_NOTBOOL;
                                        nw_next = 2'd0;
                                        sp_next = sp_reg;
                                    end
                                    else if (op_reg == OP_AND)
                                        w0_next = a_reg & b_reg;
                                    else
                                        w0_next = a_reg | b_reg;
                                end
                            endcase
                        end
                    end
                    OP_NEG, OP_PRINT, OP_DROP, OP_NOT:
                    begin
                        wbase_next = sp_reg - SP_W'(1);
                        if (sp_reg == '0)
                            st_next = ST_UNDER;
                        else if (op_reg == OP_NEG)
                        begin
                            w0_next = 32'd0 - b_reg;
                            nw_next = 2'd1;
                        end
                        else if (op_reg == OP_PRINT)
                        begin
                            em_next = 1'b1;
                            ev_next = b_reg;
                            sp_next = sp_reg - SP_W'(1);
                        end
                        else if (op_reg == OP_DROP)
                            sp_next = sp_reg - SP_W'(1);
                        else if (b_reg > 32'd1)
                            st_next = ST_NOTBOOL;
                        else
                        begin
                            w0_next = b_reg ^ 32'd1;
                            nw_next = 2'd1;
                        end
                    end
                    OP_ROT:
                    begin
                        if (sp_reg < SP_W'(3))
                            st_next = ST_UNDER;
                        else
                        begin
                            wbase_next = sp_reg - SP_W'(3);
                            w0_next = a_reg;
                            w1_next = b_reg;
                            w2_next = c_reg;
                            nw_next = 2'd3;
                        end
                    end
                    OP_DEFINE, OP_STORE:
                    begin
                        if (sp_reg == '0)
                            st_next = ST_UNDER;
                        else if (vi_bad)
                            st_next = ST_UNKVAR;
                        else if (op_reg == OP_DEFINE && def_reg[vi_reg])
                            st_next = ST_DUPVAR;
                        else if (op_reg == OP_STORE && !def_reg[vi_reg])
                            st_next = ST_UNKVAR;
                        else
                        begin
                            var_we = 1'b1;
                            def_next[vi_reg] = 1'b1;
                            sp_next = sp_reg - SP_W'(1);
                        end
                    end
                    OP_FETCH:
                    begin
                        if (vi_bad || !def_reg[vi_reg])
                            st_next = ST_UNKVAR;
                        else if (sp_reg == SP_W'(STACK_DEPTH))
                            st_next = ST_OVER;
                        else
                        begin
                            w0_next = var_rd_reg;
                            nw_next = 2'd1;
                            sp_next = sp_reg + SP_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            S_DIV:
            begin
                if (mul_pend_reg)
                begin
                    w0_next = mul_reg;
                    state_next = S_WRITE;
                end
                else if (drsp.done)
                begin
                    w0_next = drsp.result;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (wcnt_reg == nw_reg)
                    state_next = S_OUT;
                else
                begin
                    tmp_addr = wbase_reg + SP_W'(wcnt_reg);
                    wr_en = 1'b1;
                    wr_addr = tmp_addr[SA_W-1:0];
                    unique case (wcnt_reg)
                        2'd0:    wr_data = w0_reg;
                        2'd1:    wr_data = w1_reg;
                        default: wr_data = w2_reg;
                    endcase
                    wcnt_next = wcnt_reg + 2'd1;
                end
            end
            S_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next = 1'b1;
                    out_next = {5'd0, 7'(sp_reg), ev_reg, em_reg, st_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            def_reg <= '0;
            mv_reg <= 1'b0;
            rcnt_reg <= 2'd0;
            wcnt_reg <= 2'd0;
            mul_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            def_reg <= def_next;
            mv_reg <= mv_next;
            rcnt_reg <= rcnt_next;
            wcnt_reg <= wcnt_next;
            mul_pend_reg <= mul_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg <= op_t'(s_tdata[4:0]);
            lit_reg <= s_tdata[36:5];
            vi_reg <= s_tdata[40:37];
        end
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        w0_reg <= w0_next;
        w1_reg <= w1_next;
        w2_reg <= w2_next;
        nw_reg <= nw_next;
        wbase_reg <= wbase_next;
        st_reg <= st_next;
        em_reg <= em_next;
        ev_reg <= ev_next;
        out_reg <= out_next;
    end

endmodule
